FILE: rtl/core/ihex_pkg.sv
// shared types, codes and constants of the intel hex record parser
package ihex_pkg;

  localparam int MEM_BYTES    = 131072;
  localparam int TOKEN_DEPTH  = 4;
  localparam int RESULT_DEPTH = 2;

  localparam logic [20:0] MEM_LIMIT = 21'(MEM_BYTES);

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_START   = 3'd0;
  localparam logic [2:0] ERR_HEADER  = 3'd1;
  localparam logic [2:0] ERR_TYPE    = 3'd2;
  localparam logic [2:0] ERR_DISCONT = 3'd3;
  localparam logic [2:0] ERR_FIELD   = 3'd4;
  localparam logic [2:0] ERR_MEMORY  = 3'd5;

  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_SEGMENT = 8'h02;
  localparam logic [7:0] REC_START   = 8'h03;

  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_F     = 8'h46;

  typedef enum logic [2:0] {
    PH_START,
    PH_HEADER,
    PH_ENDCHK,
    PH_SEGMENT,
    PH_DATA_HI,
    PH_DATA_LO,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic       is_end;
    logic       is_nl;
    logic       is_colon;
    logic       is_f;
    logic       hex_ok;
    logic [3:0] hex_val;
  } token_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic [19:0] line_number;
    logic [19:0] last_address;
  } result_t;

endpackage

FILE: rtl/core/ihex_fifo.sv
// small register queue shared by the token and result paths
module ihex_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/core/ihex_front.sv
// front end: classifies incoming characters and queues them as tokens
module ihex_front
  import ihex_pkg::*;
#(
  parameter int DEPTH = TOKEN_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_command,
  input  logic [7:0] in_character,
  input  logic       tok_pop,
  output token_t     tok,
  output logic       tok_valid
);

  token_t                cls;
  logic [$bits(token_t)-1:0] tok_bits;
  logic                  tok_empty;
  logic                  is_digit, is_upper, is_lower;

  always_comb begin
    is_digit = (in_character >= 8'h30) && (in_character <= 8'h39);
    is_upper = (in_character >= 8'h41) && (in_character <= 8'h46);
    is_lower = (in_character >= 8'h61) && (in_character <= 8'h66);
    cls          = '0;
    cls.is_end   = in_command;
    cls.is_nl    = (in_character == CHAR_NL);
    cls.is_colon = (in_character == CHAR_COLON);
    cls.is_f     = (in_character == CHAR_F);
    cls.hex_ok   = is_digit || is_upper || is_lower;
    cls.hex_val  = is_digit ? in_character[3:0] : in_character[3:0] + 4'd9;
  end

  ihex_fifo #(
    .WIDTH($bits(token_t)),
    .DEPTH(DEPTH)
  ) u_tok_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push),
    .wr_data(cls),
    .full   (full),
    .rd_en  (tok_pop),
    .rd_data(tok_bits),
    .empty  (tok_empty)
  );

  assign tok       = token_t'(tok_bits);
  assign tok_valid = !tok_empty;

endmodule

FILE: rtl/core/ihex_back.sv
// back end: record parser state machine that turns tokens into results
module ihex_back
  import ihex_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  token_t  tok,
  input  logic    tok_valid,
  output logic    tok_pop,
  input  logic    res_room,
  output logic    res_push,
  output result_t res
);

  localparam logic [3:0] POS_LEN      = 4'd2;
  localparam logic [3:0] POS_ADDR     = 4'd6;
  localparam logic [3:0] POS_TYPE     = 4'd8;
  localparam logic [3:0] POS_END_LAST = 4'd10;
  localparam logic [3:0] POS_SEG_LAST = 4'd12;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [7:0]  bytes_r, bytes_nxt;
  logic [16:0] rec_addr_r, rec_addr_nxt;
  logic [16:0] exp_addr_r, exp_addr_nxt;
  logic        exp_valid_r, exp_valid_nxt;
  logic [19:0] seg_r, seg_nxt;
  logic [19:0] line_r, line_nxt;
  logic        stopped_r, stopped_nxt;

  logic        go;
  logic [15:0] acc_sh;
  logic [20:0] full_addr;
  logic [16:0] rec_inc;
  logic [19:0] last_addr;
  logic [2:0]  short_code;
  logic        ev_write, ev_finish, ev_error;
  logic [2:0]  ev_code;

  assign go        = tok_valid && res_room;
  assign tok_pop   = go;
  assign acc_sh    = {acc_r[11:0], tok.hex_val};
  assign full_addr = {1'b0, seg_r} + 21'(rec_addr_r);
  assign rec_inc   = rec_addr_r + 17'd1;
  assign last_addr = exp_valid_r ? seg_r + 20'(exp_addr_r) - 20'd1 : seg_r - 20'd2;

  always_comb begin
    case (phase_r)
      PH_START:  short_code = ERR_START;
      PH_HEADER: short_code = ERR_HEADER;
      PH_ENDCHK: short_code = ERR_TYPE;
      default:   short_code = ERR_FIELD;
    endcase
  end

  // result events
  always_comb begin
    ev_write  = 1'b0;
    ev_finish = 1'b0;
    ev_error  = 1'b0;
    ev_code   = ERR_START;
    if (go && !stopped_r) begin
      if (tok.is_end) begin
        if (phase_r == PH_SKIP || (phase_r == PH_START && pos_r == '0)) begin
          ev_finish = 1'b1;
        end else begin
          ev_error = 1'b1;
          ev_code  = short_code;
        end
      end else if (tok.is_nl) begin
        if (phase_r != PH_SKIP) begin
          ev_error = 1'b1;
          ev_code  = short_code;
        end
      end else begin
        case (phase_r)
          PH_START: begin
            if (!tok.is_colon) begin
              ev_error = 1'b1;
              ev_code  = ERR_START;
            end
          end
          PH_HEADER: begin
            if (!tok.hex_ok) begin
              ev_error = 1'b1;
              ev_code  = ERR_HEADER;
            end else if (pos_r == POS_TYPE) begin
              case (acc_sh[7:0])
                REC_DATA: begin
                  if (exp_valid_r && exp_addr_r != rec_addr_r) begin
                    ev_error = 1'b1;
                    ev_code  = ERR_DISCONT;
                  end
                end
                REC_EOF: begin
                  if (bytes_r != '0 || rec_addr_r != '0) begin
                    ev_error = 1'b1;
                    ev_code  = ERR_TYPE;
                  end
                end
                REC_SEGMENT, REC_START: begin
                end
                default: begin
                  ev_error = 1'b1;
                  ev_code  = ERR_TYPE;
                end
              endcase
            end
          end
          PH_ENDCHK: begin
            if (!tok.is_f) begin
              ev_error = 1'b1;
              ev_code  = ERR_TYPE;
            end else if (pos_r == POS_END_LAST) begin
              ev_finish = 1'b1;
            end
          end
          PH_SEGMENT, PH_DATA_HI: begin
            if (!tok.hex_ok) begin
              ev_error = 1'b1;
              ev_code  = ERR_FIELD;
            end
          end
          PH_DATA_LO: begin
            if (!tok.hex_ok) begin
              ev_error = 1'b1;
              ev_code  = ERR_FIELD;
            end else if (full_addr >= MEM_LIMIT) begin
              ev_error = 1'b1;
              ev_code  = ERR_MEMORY;
            end else begin
              ev_write = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    res      = '0;
    res_push = ev_write || ev_finish || ev_error;
    if (ev_write) begin
      res.kind      = KIND_WRITE;
      res.address   = full_addr[16:0];
      res.data_byte = {nib_r, tok.hex_val};
    end else if (ev_finish) begin
      res.kind         = KIND_FINISH;
      res.last_address = last_addr;
    end else if (ev_error) begin
      res.kind        = KIND_ERROR;
      res.error_code  = ev_code;
      res.line_number = line_r;
    end
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    nib_nxt       = nib_r;
    acc_nxt       = acc_r;
    bytes_nxt     = bytes_r;
    rec_addr_nxt  = rec_addr_r;
    exp_addr_nxt  = exp_addr_r;
    exp_valid_nxt = exp_valid_r;
    seg_nxt       = seg_r;
    line_nxt      = line_r;
    stopped_nxt   = stopped_r;
    if (go && !stopped_r) begin
      if (ev_finish || ev_error) begin
        stopped_nxt = 1'b1;
      end else if (tok.is_nl) begin
        if (line_r != '1) begin
          line_nxt = line_r + 20'd1;
        end
        phase_nxt = PH_START;
        pos_nxt   = '0;
      end else if (!tok.is_end) begin
        if (pos_r != '1) begin
          pos_nxt = pos_r + 4'd1;
        end
        case (phase_r)
          PH_START: begin
            acc_nxt   = '0;
            phase_nxt = PH_HEADER;
          end
          PH_HEADER: begin
            acc_nxt = acc_sh;
            if (pos_r == POS_LEN) begin
              bytes_nxt = acc_sh[7:0];
              acc_nxt   = '0;
            end else if (pos_r == POS_ADDR) begin
              rec_addr_nxt = {1'b0, acc_sh};
              acc_nxt      = '0;
            end else if (pos_r == POS_TYPE) begin
              acc_nxt = '0;
              case (acc_sh[7:0])
                REC_DATA: begin
                  exp_valid_nxt = 1'b1;
                  exp_addr_nxt  = rec_addr_r;
                  phase_nxt     = (bytes_r != '0) ? PH_DATA_HI : PH_SKIP;
                end
                REC_EOF:     phase_nxt = PH_ENDCHK;
                REC_SEGMENT: phase_nxt = PH_SEGMENT;
                REC_START:   phase_nxt = PH_SKIP;
                default: begin
                end
              endcase
            end
          end
          PH_SEGMENT: begin
            acc_nxt = acc_sh;
            if (pos_r == POS_SEG_LAST) begin
              seg_nxt       = {acc_sh, 4'b0000};
              acc_nxt       = '0;
              exp_valid_nxt = 1'b0;
              phase_nxt     = PH_SKIP;
            end
          end
          PH_DATA_HI: begin
            nib_nxt   = tok.hex_val;
            phase_nxt = PH_DATA_LO;
          end
          PH_DATA_LO: begin
            rec_addr_nxt = rec_inc;
            exp_addr_nxt = rec_inc;
            bytes_nxt    = bytes_r - 8'd1;
            phase_nxt    = (bytes_r != 8'd1) ? PH_DATA_HI : PH_SKIP;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      pos_r       <= '0;
      nib_r       <= '0;
      acc_r       <= '0;
      bytes_r     <= '0;
      rec_addr_r  <= '0;
      exp_addr_r  <= '0;
      exp_valid_r <= 1'b0;
      seg_r       <= '0;
      line_r      <= 20'd1;
      stopped_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      nib_r       <= nib_nxt;
      acc_r       <= acc_nxt;
      bytes_r     <= bytes_nxt;
      rec_addr_r  <= rec_addr_nxt;
      exp_addr_r  <= exp_addr_nxt;
      exp_valid_r <= exp_valid_nxt;
      seg_r       <= seg_nxt;
      line_r      <= line_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

endmodule

FILE: rtl/core/intel_hex_record_parser.sv
// intel hex record parser top level
// Characters of a hex file go in through a queue-style port: push with
// in_command 0 and the byte on in_character, or in_command 1 for end of
// input; an item is taken when push is high and full is low.
// Results come out of a second queue: while empty is low the oldest result
// sits on the out_ ports (byte write, finished or error) and pop takes it.
// An item is registered in the token queue and its result in the result queue
// before the result shows on out_. One item per cycle is sustained unless the
// result queue is full. Items wait in a token queue of TOKEN_DEPTH entries;
// results in a result queue of RESULT_DEPTH entries. When the receiver stalls,
// the result queue fills, the parser holds, the token queue fills, full rises.
// After a finished or error result the block drops all input until reset.
// Reset (synchronous, active low) empties both queues and returns the
// parser to the start of line one with segment base zero.
module intel_hex_record_parser
  import ihex_pkg::*;
#(
  parameter int TOKEN_DEPTH  = ihex_pkg::TOKEN_DEPTH,
  parameter int RESULT_DEPTH = ihex_pkg::RESULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_command,
  input  logic [7:0]  in_character,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [16:0] out_address,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_error_code,
  output logic [19:0] out_line_number,
  output logic [19:0] out_last_address
);

  token_t  tok;
  logic    tok_valid, tok_pop;
  logic    res_push, res_full;
  result_t res, res_head;
  logic [$bits(result_t)-1:0] res_bits;

  ihex_front #(
    .DEPTH(TOKEN_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_command  (in_command),
    .in_character(in_character),
    .tok_pop     (tok_pop),
    .tok         (tok),
    .tok_valid   (tok_valid)
  );

  ihex_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok      (tok),
    .tok_valid(tok_valid),
    .tok_pop  (tok_pop),
    .res_room (!res_full),
    .res_push (res_push),
    .res      (res)
  );

  ihex_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RESULT_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_bits),
    .empty  (empty)
  );

  assign res_head         = result_t'(res_bits);
  assign out_kind         = res_head.kind;
  assign out_address      = res_head.address;
  assign out_data_byte    = res_head.data_byte;
  assign out_error_code   = res_head.error_code;
  assign out_line_number  = res_head.line_number;
  assign out_last_address = res_head.last_address;

endmodule

FILE: rtl/core/ihex_checker.sv
// port-level assertions for the intel hex record parser, bound to the top
module ihex_checker
  import ihex_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_kind,
  input logic [16:0] out_address,
  input logic [7:0]  out_data_byte,
  input logic [2:0]  out_error_code,
  input logic [19:0] out_line_number,
  input logic [19:0] out_last_address
);

  // queues come out of reset empty
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (empty && !full))
    else $error("queues not clear after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_kind == KIND_WRITE || out_kind == KIND_FINISH ||
                out_kind == KIND_ERROR))
    else $error("illegal result kind");

  // nothing follows a finished or error item
  a_last_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && out_kind != KIND_WRITE) |=> empty)
    else $error("item after finish or error");

  a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_WRITE) |->
      (out_error_code == '0 && out_line_number == '0 && out_last_address == '0))
    else $error("write item carries stray fields");

  a_error_line: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_ERROR) |->
      (out_line_number != '0 && out_address == '0 && out_data_byte == '0))
    else $error("error item without line number");

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);
